/* hdl/rrbwa_pkg.sv */
// Shared types and constants of the round-robin bank write arbiter.
`timescale 1ns / 1ps
package rrbwa_pkg;

	localparam int CLIENT_W         = 2;
	localparam int ADDR_W           = 17;
	localparam int DATA_W           = 64;
	localparam int MASK_W           = 4;
	localparam int BANK_W           = 2;
	localparam int LINE_OFFSET_BITS = 9;
	localparam int SUBARRAY_BITS    = 2;
	localparam int BANK_SHIFT       = LINE_OFFSET_BITS + SUBARRAY_BITS;
	localparam int IN_W             = 88;
	localparam int OUT_W            = 88;

	// Beat kind carried on s_tuser
	typedef enum logic {
		OP_POST = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	// Input tdata layout, lowest field last
	typedef struct packed {
		logic              pad;
		logic [MASK_W-1:0] bank_ready_mask;
		logic [DATA_W-1:0] write_data;
		logic [ADDR_W-1:0] array_addr;
		logic [CLIENT_W-1:0] client;
	} in_beat_t;

	// Output tdata layout, lowest field last
	typedef struct packed {
		logic [DATA_W-1:0]   commit_data;
		logic [ADDR_W-1:0]   commit_addr;
		logic [BANK_W-1:0]   commit_bank;
		logic                grant_committed;
		logic [CLIENT_W-1:0] grant_client;
		logic                grant_valid;
		logic                accepted;
	} result_t;

	// Slot store commands from the control logic
	typedef struct packed {
		logic                post_en;
		logic [CLIENT_W-1:0] post_client;
		logic                take_en;
		logic [CLIENT_W-1:0] take_client;
	} slot_cmd_t;

	// Round-robin pick from the slot store
	typedef struct packed {
		logic                valid;
		logic [CLIENT_W-1:0] client;
	} pick_t;

	// Bank decode from the array address
	function automatic logic [BANK_W-1:0] bank_of(input logic [ADDR_W-1:0] addr);
		return addr[BANK_SHIFT +: BANK_W];
	endfunction

endpackage

/* hdl/rrbwa_slots.sv */
// Per-client request slots with round-robin pick after the last grant.
`timescale 1ns / 1ps
module rrbwa_slots #(
	parameter int NUM_CLIENTS = 3
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rrbwa_pkg::slot_cmd_t          cmd,
	input  logic [rrbwa_pkg::ADDR_W-1:0]  post_addr,
	input  logic [rrbwa_pkg::DATA_W-1:0]  post_data,
	output logic [NUM_CLIENTS-1:0]        slot_full,
	output rrbwa_pkg::pick_t              pick,
	output logic [rrbwa_pkg::ADDR_W-1:0]  pick_addr,
	output logic [rrbwa_pkg::DATA_W-1:0]  pick_data
);

	localparam int IDX_W = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
	localparam int SUM_W = IDX_W + 1;

	logic [NUM_CLIENTS-1:0]       valid_q;
	logic [IDX_W-1:0]             last_q;
	logic [rrbwa_pkg::ADDR_W-1:0] addr_q [NUM_CLIENTS];
	logic [rrbwa_pkg::DATA_W-1:0] data_q [NUM_CLIENTS];
	logic [IDX_W-1:0]             post_idx;
	logic [IDX_W-1:0]             take_idx;
	logic [IDX_W-1:0]             pick_idx;

	assign post_idx  = cmd.post_client[IDX_W-1:0];
	assign take_idx  = cmd.take_client[IDX_W-1:0];
	assign slot_full = valid_q;

	// Scan clients starting just after the last grant
	always_comb begin
		logic [SUM_W-1:0] s;
		logic [IDX_W-1:0] idx;
		logic             found;
		found    = 1'b0;
		pick_idx = '0;
		for (int i = 1; i <= NUM_CLIENTS; i++) begin
			s = SUM_W'(last_q) + SUM_W'(i);
			if (s >= SUM_W'(NUM_CLIENTS)) begin
				s = s - SUM_W'(NUM_CLIENTS);
			end
			idx = s[IDX_W-1:0];
			if (!found && valid_q[idx]) begin
				found    = 1'b1;
				pick_idx = idx;
			end
		end
		pick.valid  = found;
		pick.client = rrbwa_pkg::CLIENT_W'(pick_idx);
	end

	assign pick_addr = addr_q[pick_idx];
	assign pick_data = data_q[pick_idx];

	// Valid bits and round-robin pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			last_q  <= IDX_W'(NUM_CLIENTS - 1);
		end else begin
			if (cmd.post_en) begin
				valid_q[post_idx] <= 1'b1;
			end
			if (cmd.take_en) begin
				valid_q[take_idx] <= 1'b0;
				last_q            <= take_idx;
			end
		end
	end

	// Slot payload, written on post
	always_ff @(posedge clk) begin
		if (cmd.post_en) begin
			addr_q[post_idx] <= post_addr;
			data_q[post_idx] <= post_data;
		end
	end

endmodule

/* hdl/rrbwa_ctrl.sv */
// Arbitration control: post handling, grant, bank check and blocked hold.
`timescale 1ns / 1ps
module rrbwa_ctrl #(
	parameter int NUM_CLIENTS = 3
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  rrbwa_pkg::op_t                op,
	input  rrbwa_pkg::in_beat_t           beat,
	input  logic [NUM_CLIENTS-1:0]        slot_full,
	input  rrbwa_pkg::pick_t              pick,
	input  logic [rrbwa_pkg::ADDR_W-1:0]  pick_addr,
	input  logic [rrbwa_pkg::DATA_W-1:0]  pick_data,
	output rrbwa_pkg::slot_cmd_t          cmd,
	output rrbwa_pkg::result_t            result
);

	localparam int IDX_W = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
	localparam int CMP_W = rrbwa_pkg::CLIENT_W + 1;

	logic                           blocked_q;
	logic [rrbwa_pkg::CLIENT_W-1:0] held_client_q;
	logic [rrbwa_pkg::BANK_W-1:0]   held_bank_q;
	logic [rrbwa_pkg::ADDR_W-1:0]   held_addr_q;
	logic [rrbwa_pkg::DATA_W-1:0]   held_data_q;

	logic                           in_range;
	logic [rrbwa_pkg::BANK_W-1:0]   pick_bank;
	logic                           set_block;
	logic                           clr_block;

	assign in_range  = CMP_W'(beat.client) < CMP_W'(NUM_CLIENTS);
	assign pick_bank = rrbwa_pkg::bank_of(pick_addr);

	// Result and slot commands for the beat in the input register
	always_comb begin
		result    = '0;
		cmd       = '0;
		set_block = 1'b0;
		clr_block = 1'b0;
		case (op)
			rrbwa_pkg::OP_POST: begin
				if (in_range && !slot_full[beat.client[IDX_W-1:0]]) begin
					cmd.post_en     = en;
					cmd.post_client = beat.client;
					result.accepted = 1'b1;
				end
			end
			rrbwa_pkg::OP_TICK: begin
				if (blocked_q) begin
					// only the held bank is checked while blocked
					if (beat.bank_ready_mask[held_bank_q]) begin
						clr_block              = en;
						result.grant_valid     = 1'b1;
						result.grant_client    = held_client_q;
						result.grant_committed = 1'b1;
						result.commit_bank     = held_bank_q;
						result.commit_addr     = held_addr_q;
						result.commit_data     = held_data_q;
					end
				end else if (pick.valid) begin
					cmd.take_en         = en;
					cmd.take_client     = pick.client;
					result.grant_valid  = 1'b1;
					result.grant_client = pick.client;
					if (beat.bank_ready_mask[pick_bank]) begin
						result.grant_committed = 1'b1;
						result.commit_bank     = pick_bank;
						result.commit_addr     = pick_addr;
						result.commit_data     = pick_data;
					end else begin
						set_block = en;
					end
				end
			end
			default: begin
				result = '0;
			end
		endcase
	end

	// Access / blocked state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blocked_q     <= 1'b0;
			held_client_q <= '0;
			held_bank_q   <= '0;
		end else if (set_block) begin
			blocked_q     <= 1'b1;
			held_client_q <= pick.client;
			held_bank_q   <= pick_bank;
		end else if (clr_block) begin
			blocked_q <= 1'b0;
		end
	end

	// Held write payload
	always_ff @(posedge clk) begin
		if (set_block) begin
			held_addr_q <= pick_addr;
			held_data_q <= pick_data;
		end
	end

endmodule

/* hdl/round_robin_bank_write_arbiter_unit.sv */
// Top level: input register, arbitration logic and output register.
// A beat goes from the input register through the arbitration logic to the output register.
// Throughput: one beat per cycle unless m_tready stalls, set by a single pass through the
// slot pick and bank check between the two registers; one result beat per input beat.
// Reset (arst_n low, asynchronous): slots empty, pointer on the last client,
// access state, both pipeline registers empty.
`timescale 1ns / 1ps
module round_robin_bank_write_arbiter_unit #(
	parameter int NUM_CLIENTS = 3 // 2 to 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// client[1:0], array_addr[18:2], write_data[82:19], bank_ready_mask[86:83], zero
	input  logic [rrbwa_pkg::IN_W-1:0]   s_tdata,
	// opcode[0]
	input  logic [0:0]                   s_tuser,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// accepted[0], grant_valid[1], grant_client[3:2], grant_committed[4],
	// commit_bank[6:5], commit_addr[23:7], commit_data[87:24]
	output logic [rrbwa_pkg::OUT_W-1:0]  m_tdata
);

	logic                         valid_s1;
	rrbwa_pkg::in_beat_t          beat_s1;
	rrbwa_pkg::op_t               op_s1;
	logic                         valid_s2;
	rrbwa_pkg::result_t           res_s2;

	logic                         adv;
	rrbwa_pkg::slot_cmd_t         cmd;
	rrbwa_pkg::pick_t             pick;
	logic [NUM_CLIENTS-1:0]       slot_full;
	logic [rrbwa_pkg::ADDR_W-1:0] pick_addr;
	logic [rrbwa_pkg::DATA_W-1:0] pick_data;
	rrbwa_pkg::result_t           result;

	// Beat moves from s1 to s2 when s2 is empty or being drained
	assign adv      = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign m_tvalid = valid_s2;
	assign m_tdata  = res_s2;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			beat_s1 <= rrbwa_pkg::in_beat_t'(s_tdata);
			op_s1   <= rrbwa_pkg::op_t'(s_tuser[0]);
		end
	end

	rrbwa_slots #(
		.NUM_CLIENTS(NUM_CLIENTS)
	) u_slots (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.post_addr (beat_s1.array_addr),
		.post_data (beat_s1.write_data),
		.slot_full (slot_full),
		.pick      (pick),
		.pick_addr (pick_addr),
		.pick_data (pick_data)
	);

	rrbwa_ctrl #(
		.NUM_CLIENTS(NUM_CLIENTS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.op        (op_s1),
		.beat      (beat_s1),
		.slot_full (slot_full),
		.pick      (pick),
		.pick_addr (pick_addr),
		.pick_data (pick_data),
		.cmd       (cmd),
		.result    (result)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= result;
		end
	end

endmodule

/* hdl/rrbwa_checker.sv */
// Port-level checks of the arbiter and their bind to the top level.
`timescale 1ns / 1ps
module rrbwa_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [rrbwa_pkg::OUT_W-1:0] m_tdata
);

	rrbwa_pkg::result_t res;
	assign res = rrbwa_pkg::result_t'(m_tdata);

	// A stalled result beat keeps its value
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// A post answer carries nothing but the accept flag
	a_post_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res.accepted |-> m_tdata[rrbwa_pkg::OUT_W-1:1] == '0)
		else $error("accepted beat carries grant fields");

	// A commit only comes with a grant
	a_commit_grant: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res.grant_committed |-> res.grant_valid)
		else $error("commit without grant");

	// Commit fields are zero when nothing was committed
	a_commit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !res.grant_committed |->
			res.commit_bank == '0 && res.commit_addr == '0 && res.commit_data == '0)
		else $error("commit fields set without commit");

	// Grant client is zero on beats without a grant
	a_client_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !res.grant_valid |-> res.grant_client == '0)
		else $error("grant client set without grant");

endmodule

bind round_robin_bank_write_arbiter_unit rrbwa_checker u_rrbwa_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

/* sim/tb_top.sv */
// Self-checking testbench of the round-robin bank write arbiter.
`timescale 1ns / 1ps
module tb_top;

	localparam int CLIENTS      = 3;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 8;
	localparam int IN_W         = rrbwa_pkg::IN_W;
	localparam int OUT_W        = rrbwa_pkg::OUT_W;
	localparam int CLIENT_W     = rrbwa_pkg::CLIENT_W;
	localparam int ADDR_W       = rrbwa_pkg::ADDR_W;
	localparam int DATA_W       = rrbwa_pkg::DATA_W;
	localparam int MASK_W       = rrbwa_pkg::MASK_W;
	localparam int BANK_W       = rrbwa_pkg::BANK_W;
	localparam int BANK_SHIFT   = rrbwa_pkg::BANK_SHIFT;

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata;
	logic [0:0]       s_tuser;
	logic             m_tvalid;
	logic             m_tready;
	logic [OUT_W-1:0] m_tdata;

	// arbiter state mirrored by the predictor
	logic [CLIENTS-1:0]  pend_valid;
	logic [ADDR_W-1:0]   pend_addr [CLIENTS];
	logic [DATA_W-1:0]   pend_data [CLIENTS];
	logic [CLIENT_W-1:0] rr_last;
	logic                stalled;
	logic [CLIENT_W-1:0] stall_client;
	logic [ADDR_W-1:0]   stall_addr;
	logic [DATA_W-1:0]   stall_data;
	logic [BANK_W-1:0]   stall_bank;

	rrbwa_pkg::result_t due_results[$];
	rrbwa_pkg::result_t got_beat;
	rrbwa_pkg::result_t want_beat;
	int      mismatches  = 0;
	int      idle_cycles = 0;
	bit      calm        = 1'b0;

	round_robin_bank_write_arbiter_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Expected result of one beat; updates the mirrored state
	function automatic rrbwa_pkg::result_t arbitrate_beat(input rrbwa_pkg::op_t op,
			input rrbwa_pkg::in_beat_t b);
		rrbwa_pkg::result_t r;
		int                 k;
		int                 idx;
		logic [BANK_W-1:0]  bank;
		r = '0;
		if (op == rrbwa_pkg::OP_POST) begin
			if (b.client < CLIENTS && !pend_valid[b.client]) begin
				pend_valid[b.client] = 1'b1;
				pend_addr[b.client]  = b.array_addr;
				pend_data[b.client]  = b.write_data;
				r.accepted           = 1'b1;
			end
		end else if (stalled) begin
			// only the held bank is looked at
			if (b.bank_ready_mask[stall_bank]) begin
				stalled           = 1'b0;
				r.grant_valid     = 1'b1;
				r.grant_client    = stall_client;
				r.grant_committed = 1'b1;
				r.commit_bank     = stall_bank;
				r.commit_addr     = stall_addr;
				r.commit_data     = stall_data;
			end
		end else begin
			// rotate priority, starting after the last grant
			for (k = 1; k <= CLIENTS; k++) begin
				idx = (rr_last + k) % CLIENTS;
				if (pend_valid[idx] && !r.grant_valid) begin
					pend_valid[idx] = 1'b0;
					rr_last         = CLIENT_W'(idx);
					bank            = pend_addr[idx][BANK_SHIFT +: BANK_W];
					r.grant_valid   = 1'b1;
					r.grant_client  = CLIENT_W'(idx);
					if (b.bank_ready_mask[bank]) begin
						r.grant_committed = 1'b1;
						r.commit_bank     = bank;
						r.commit_addr     = pend_addr[idx];
						r.commit_data     = pend_data[idx];
					end else begin
						stalled      = 1'b1;
						stall_client = CLIENT_W'(idx);
						stall_addr   = pend_addr[idx];
						stall_data   = pend_data[idx];
						stall_bank   = bank;
					end
				end
			end
		end
		return r;
	endfunction

	// Random address that decodes to the given bank
	function automatic logic [ADDR_W-1:0] bank_addr(input logic [BANK_W-1:0] bank);
		logic [ADDR_W-1:0] a;
		a = ADDR_W'($urandom);
		a[BANK_SHIFT +: BANK_W] = bank;
		return a;
	endfunction

	// Drive one input beat, wait for its handshake, queue its result
	task automatic send_beat(input rrbwa_pkg::op_t op, input rrbwa_pkg::in_beat_t b);
		int gap;
		rrbwa_pkg::result_t want;
		if (!calm && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 15);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= op;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		want = arbitrate_beat(op, b);
		due_results.insert(due_results.size(), want);
	endtask

	task automatic post(input logic [CLIENT_W-1:0] who, input logic [ADDR_W-1:0] addr,
			input logic [DATA_W-1:0] data);
		rrbwa_pkg::in_beat_t b;
		b                 = '0;
		b.client          = who;
		b.array_addr      = addr;
		b.write_data      = data;
		b.bank_ready_mask = MASK_W'($urandom);
		send_beat(rrbwa_pkg::OP_POST, b);
	endtask

	task automatic tick(input logic [MASK_W-1:0] mask);
		rrbwa_pkg::in_beat_t b;
		b                 = '0;
		b.client          = CLIENT_W'($urandom);
		b.array_addr      = ADDR_W'($urandom);
		b.write_data      = {$urandom, $urandom};
		b.bank_ready_mask = mask;
		send_beat(rrbwa_pkg::OP_TICK, b);
	endtask

	// Extremes, refusals, stall and release, round-robin wrap
	task automatic test_directed_cases();
		tick(4'hF);                                // nothing pending: all zero
		post(2'd0, '0, '0);
		post(2'd0, '1, '1);                        // slot still full: refused
		post(2'd3, '1, '1);                        // client out of range: ignored
		post(2'd1, '1, '1);                        // bank 3
		post(2'd2, bank_addr(2'd2), 64'hA5A5_A5A5_A5A5_A5A5);
		tick(4'hF);                                // client 0 commits to bank 0
		tick(4'h7);                                // client 1, bank 3 busy: stall
		post(2'd1, bank_addr(2'd1), 64'h5A5A_5A5A_5A5A_5A5A);  // post while stalled
		post(2'd0, bank_addr(2'd0), 64'h0123_4567_89AB_CDEF);
		tick(4'h7);                                // held bank still busy
		tick(4'h0);
		tick(4'h8);                                // held write goes out
		tick(4'h4);                                // client 2, bank 2
		tick(4'hD);                                // wrap to client 0
		tick(4'h0);                                // client 1, bank 1 busy
		tick(4'hF);                                // release
		tick(4'hF);                                // empty again
	endtask

	// Mostly posts to free slots and ticks; some posts to full or bad slots
	task automatic test_random_traffic(input int count);
		int                  roll;
		int                  pick;
		logic [CLIENT_W-1:0] who;
		logic [MASK_W-1:0]   mask;
		repeat (count) begin
			roll = $urandom_range(0, 99);
			if (roll < 45 && pend_valid != '1) begin
				who = CLIENT_W'($urandom_range(0, CLIENTS - 1));
				while (pend_valid[who]) who = CLIENT_W'($urandom_range(0, CLIENTS - 1));
				post(who, ADDR_W'($urandom), {$urandom, $urandom});
			end else if (roll < 53) begin
				post(CLIENT_W'($urandom_range(0, 3)), ADDR_W'($urandom), {$urandom, $urandom});
			end else begin
				pick = $urandom_range(0, 9);
				if (pick < 5)
					mask = MASK_W'($urandom);
				else if (pick < 8)
					mask = '1;
				else
					mask = '0;
				tick(mask);
			end
		end
	endtask

	// Same traffic with both sides running at full rate
	task automatic test_full_rate(input int count);
		calm = 1'b1;
		test_random_traffic(count);
	endtask

	// Result side: ready in random runs, broken by random stalls outside the full-rate test
	initial begin
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 40)) @(posedge clk);
			if (!calm) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
		end
	end

	// Compare each result beat with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_beat = m_tdata;
			if (due_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat %h", got_beat);
			end else begin
				want_beat = due_results.pop_front();
				if (got_beat.accepted        !== want_beat.accepted        ||
				    got_beat.grant_valid     !== want_beat.grant_valid     ||
				    got_beat.grant_client    !== want_beat.grant_client    ||
				    got_beat.grant_committed !== want_beat.grant_committed ||
				    got_beat.commit_bank     !== want_beat.commit_bank     ||
				    got_beat.commit_addr     !== want_beat.commit_addr     ||
				    got_beat.commit_data     !== want_beat.commit_data) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch (exp/got): acc %b/%b gv %b/%b gc %0d/%0d cm %b/%b",
							want_beat.accepted, got_beat.accepted,
							want_beat.grant_valid, got_beat.grant_valid,
							want_beat.grant_client, got_beat.grant_client,
							want_beat.grant_committed, got_beat.grant_committed);
						$display("  bank %0d/%0d addr %h/%h data %h/%h",
							want_beat.commit_bank, got_beat.commit_bank,
							want_beat.commit_addr, got_beat.commit_addr,
							want_beat.commit_data, got_beat.commit_data);
					end
				end
			end
		end
	end

	// Watchdog: cycles without a beat on either side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			idle_cycles <= 0;
		else if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (idle_cycles >= IDLE_LIMIT);
		$display("[round_robin_bank_write_arbiter_unit] ERROR");
		$finish;
	end

	// Test sequence
	initial begin
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= rrbwa_pkg::OP_POST;
		pend_valid   = '0;
		rr_last      = CLIENT_W'(CLIENTS - 1);
		stalled      = 1'b0;
		stall_client = '0;
		stall_bank   = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_random_traffic(1000);
		test_full_rate(330);

		s_tvalid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("[round_robin_bank_write_arbiter_unit] OK");
		else
			$display("[round_robin_bank_write_arbiter_unit] ERROR");
		$finish;
	end

endmodule
